### rtl/fcnt_pkg.sv
// shared types and constants for the flash counter keeper
`timescale 1ns / 1ps
`default_nettype none

package fcnt_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FAIL_W  = 5;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned REQ_W   = 3;

  localparam logic [FAIL_W-1:0] FAIL_MAX = 5'd31;

  typedef enum logic [REQ_W-1:0] {
    REQ_NEXT    = 3'd0,
    REQ_SET     = 3'd1,
    REQ_FAIL    = 3'd2,
    REQ_PIN_RST = 3'd3,
    REQ_CLEAR   = 3'd4,
    REQ_READ    = 3'd5
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] new_value;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  pin_slot;
    logic               area_recycled;
    logic               pin_saturated;
    logic [FAIL_W-1:0]  pin_failures;
    logic [VALUE_W-1:0] counter_value;
  } result_t;

endpackage

`default_nettype wire

### rtl/fcnt_in_stage.sv
// input register holding one accepted request
`timescale 1ns / 1ps
`default_nettype none

module fcnt_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fcnt_pkg::item_t in_item,
  output logic                held_valid,
  input  wire logic           held_take,
  output fcnt_pkg::item_t     held_item
);

  logic valid;
  fcnt_pkg::item_t item;

  // room when empty or when the held request moves on this cycle
  assign in_ready   = !valid || held_take;
  assign held_valid = valid;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/fcnt_core.sv
// counter and pin state with the per-request update logic
`timescale 1ns / 1ps
`default_nettype none

module fcnt_core #(
  parameter int unsigned PIN_SLOTS    = 1024,
  parameter int unsigned COUNTER_BITS = 2048
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire fcnt_pkg::item_t  item,
  output fcnt_pkg::result_t     result
);

  localparam int unsigned CW = (COUNTER_BITS > 1) ? $clog2(COUNTER_BITS) : 1;
  localparam int unsigned SW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
  localparam logic [CW:0] CNT_LIM  = COUNTER_BITS[CW:0];
  localparam logic [SW:0] SLOT_LIM = PIN_SLOTS[SW:0];

  logic [fcnt_pkg::VALUE_W-1:0] counter_base, counter_base_next;
  logic [CW-1:0]                cleared_bits, cleared_bits_next;
  logic [SW-1:0]                slot_index, slot_index_next;
  logic [fcnt_pkg::FAIL_W-1:0]  fail_count, fail_count_next;
  logic                         saturated, recycled;

  logic [CW:0]                  cleared_inc;
  logic [SW:0]                  slot_inc;
  logic [fcnt_pkg::VALUE_W-1:0] cleared_ext, cleared_next_ext, slot_next_ext;

  assign cleared_inc = {1'b0, cleared_bits} + 1'b1;
  assign slot_inc    = {1'b0, slot_index} + 1'b1;
  assign cleared_ext = fcnt_pkg::VALUE_W'(cleared_bits);

  always_comb begin
    counter_base_next = counter_base;
    cleared_bits_next = cleared_bits;
    slot_index_next   = slot_index;
    fail_count_next   = fail_count;
    saturated         = 1'b0;
    recycled          = 1'b0;
    case (fcnt_pkg::req_t'(item.req_type))
      fcnt_pkg::REQ_NEXT: begin
        if (cleared_inc >= CNT_LIM) begin
          // area full: fold the whole offset into the base
          counter_base_next = counter_base + fcnt_pkg::VALUE_W'(cleared_inc);
          cleared_bits_next = '0;
          slot_index_next   = '0;
          recycled          = 1'b1;
        end else begin
          cleared_bits_next = cleared_inc[CW-1:0];
        end
      end
      fcnt_pkg::REQ_SET: begin
        counter_base_next = item.new_value - cleared_ext;
      end
      fcnt_pkg::REQ_FAIL: begin
        if (fail_count >= fcnt_pkg::FAIL_MAX) begin
          fail_count_next = fcnt_pkg::FAIL_MAX;
          saturated       = 1'b1;
        end else begin
          fail_count_next = fail_count + 1'b1;
        end
      end
      fcnt_pkg::REQ_PIN_RST: begin
        if (slot_inc >= SLOT_LIM) begin
          counter_base_next = counter_base + cleared_ext;
          cleared_bits_next = '0;
          slot_index_next   = '0;
          recycled          = 1'b1;
        end else begin
          slot_index_next = slot_inc[SW-1:0];
        end
        fail_count_next = '0;
      end
      fcnt_pkg::REQ_CLEAR: begin
        cleared_bits_next = '0;
        slot_index_next   = '0;
        fail_count_next   = '0;
      end
      default: begin
      end
    endcase
  end

  assign cleared_next_ext = fcnt_pkg::VALUE_W'(cleared_bits_next);
  assign slot_next_ext    = fcnt_pkg::VALUE_W'(slot_index_next);

  always_comb begin
    result.counter_value = counter_base_next + cleared_next_ext;
    result.pin_failures  = fail_count_next;
    result.pin_saturated = saturated;
    result.area_recycled = recycled;
    result.pin_slot      = slot_next_ext[fcnt_pkg::SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_base <= '0;
      cleared_bits <= '0;
      slot_index   <= '0;
      fail_count   <= '0;
    end else if (step) begin
      counter_base <= counter_base_next;
      cleared_bits <= cleared_bits_next;
      slot_index   <= slot_index_next;
      fail_count   <= fail_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/fcnt_out_stage.sv
// result register toward the output stream
`timescale 1ns / 1ps
`default_nettype none

module fcnt_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire fcnt_pkg::result_t load_data,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fcnt_pkg::result_t      out_data
);

  logic valid;
  fcnt_pkg::result_t data;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

### rtl/flash_unary_counter_keeper.sv
// Monotonic counter and pin failure counter kept as bit-clearing flash areas.
// Requests arrive on the s_axis stream: tuser carries the request code
// (next counter, set counter, pin failure, pin reset, clear area, read) and
// tdata carries the value for a set counter request. Codes 6 and 7 act as read.
// Every request yields exactly one result transfer on the m_axis stream with
// the counter value, pin failure count, saturation and recycle flags and the
// current pin slot.
// The result is registered: each request passes the input register, then the
// state update and the result register.
// Throughput is one request per cycle while the receiver takes results; the
// state update is a single add and compare between the input register and the
// state registers.
// When the receiver stalls, the result register holds and one more request
// waits in the input register; after that s_axis_tready drops.
// Synchronous reset clears the counter base, the offset, the pin slot and the
// failure count to zero and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module flash_unary_counter_keeper #(
  parameter int unsigned PIN_SLOTS    = 1024,
  parameter int unsigned COUNTER_BITS = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // new_value[31:0]
  input  wire logic [7:0]  s_axis_tuser,  // req_type[2:0], zeros above
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // counter_value[31:0], pin_failures[36:32], pin_saturated[37],
  // area_recycled[38], pin_slot[48:39], zeros above
  output logic [55:0]      m_axis_tdata
);

  fcnt_pkg::item_t   in_item, held_item;
  fcnt_pkg::result_t result, out_data;
  logic              held_valid, out_free, step;

  assign in_item.req_type  = s_axis_tuser[fcnt_pkg::REQ_W-1:0];
  assign in_item.new_value = s_axis_tdata;

  // a held request is processed whenever the result register can take it
  assign step = held_valid && out_free;

  fcnt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (step),
    .held_item  (held_item)
  );

  fcnt_core #(
    .PIN_SLOTS    (PIN_SLOTS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .result (result)
  );

  fcnt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .load_data (result),
    .free      (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {7'd0, out_data};

endmodule

`default_nettype wire

### sim/tb_top.sv
// testbench for the flash counter keeper: stream driver, predictor and scoreboard
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PIN_SLOTS    = 1024;
  localparam int unsigned COUNTER_BITS = 2048;
  localparam logic [fcnt_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [fcnt_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int unsigned RES_W = $bits(fcnt_pkg::result_t);

  typedef enum {LOAD_MIXED, LOAD_FAILS, LOAD_COUNTER_WEAR, LOAD_PIN_WEAR} load_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // new_value[31:0]
  logic [7:0]  s_axis_tuser;   // req_type[2:0], zeros above
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // counter_value[31:0], pin_failures[36:32], pin_saturated[37],
  // area_recycled[38], pin_slot[48:39], zeros above
  logic [55:0] m_axis_tdata;

  int tx_gap_max;
  int rx_stall_max;

  flash_unary_counter_keeper #(
    .PIN_SLOTS(PIN_SLOTS),
    .COUNTER_BITS(COUNTER_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  class counter_scoreboard;
    logic [fcnt_pkg::VALUE_W-1:0] base;
    logic [11:0]                  offset;
    logic [fcnt_pkg::SLOT_W-1:0]  slot;
    logic [fcnt_pkg::FAIL_W-1:0]  fails;
    fcnt_pkg::result_t            awaited[$];
    int errors;
    int checked;
    int folds_by_counter;
    int folds_by_pin;
    int saturations;
    int req_seen[8];

    function new();
      base = '0;
      offset = '0;
      slot = '0;
      fails = '0;
      errors = 0;
      checked = 0;
      folds_by_counter = 0;
      folds_by_pin = 0;
      saturations = 0;
      foreach (req_seen[i]) req_seen[i] = 0;
    endfunction

    function void fold_offset();
      base = base + fcnt_pkg::VALUE_W'(offset);
      offset = '0;
      slot = '0;
    endfunction

    function void note_request(logic [fcnt_pkg::REQ_W-1:0] code,
                               logic [fcnt_pkg::VALUE_W-1:0] value);
      fcnt_pkg::result_t r;
      logic sat;
      logic folded;
      sat = 1'b0;
      folded = 1'b0;
      req_seen[code]++;
      case (code)
        fcnt_pkg::REQ_NEXT: begin
          offset = offset + 1'b1;
          if (int'(offset) >= COUNTER_BITS) begin
            fold_offset();
            folded = 1'b1;
            folds_by_counter++;
          end
        end
        fcnt_pkg::REQ_SET: base = value - fcnt_pkg::VALUE_W'(offset);
        fcnt_pkg::REQ_FAIL: begin
          if (fails >= fcnt_pkg::FAIL_MAX) begin
            sat = 1'b1;
            saturations++;
          end else begin
            fails = fails + 1'b1;
          end
        end
        fcnt_pkg::REQ_PIN_RST: begin
          // last slot used up: both areas get recycled
          if (int'(slot) + 1 >= PIN_SLOTS) begin
            fold_offset();
            folded = 1'b1;
            folds_by_pin++;
          end else begin
            slot = slot + 1'b1;
          end
          fails = '0;
        end
        fcnt_pkg::REQ_CLEAR: begin
          offset = '0;
          slot = '0;
          fails = '0;
        end
        default: ;
      endcase
      r.counter_value = base + fcnt_pkg::VALUE_W'(offset);
      r.pin_failures  = fails;
      r.pin_saturated = sat;
      r.area_recycled = folded;
      r.pin_slot      = slot;
      awaited.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(fcnt_pkg::result_t got);
      fcnt_pkg::result_t want;
      if (awaited.size() == 0) begin
        report("unexpected result transfer", got.counter_value, 32'd0);
      end else begin
        want = awaited.pop_front();
        checked++;
        if (got.counter_value !== want.counter_value)
          report("counter_value", got.counter_value, want.counter_value);
        if (got.pin_failures !== want.pin_failures)
          report("pin_failures", 32'(got.pin_failures), 32'(want.pin_failures));
        if (got.pin_saturated !== want.pin_saturated)
          report("pin_saturated", 32'(got.pin_saturated), 32'(want.pin_saturated));
        if (got.area_recycled !== want.area_recycled)
          report("area_recycled", 32'(got.area_recycled), 32'(want.area_recycled));
        if (got.pin_slot !== want.pin_slot)
          report("pin_slot", 32'(got.pin_slot), 32'(want.pin_slot));
      end
    endtask
  endclass

  counter_scoreboard sb = new();

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task send_req(logic [fcnt_pkg::REQ_W-1:0] code, logic [fcnt_pkg::VALUE_W-1:0] value);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {5'd0, code};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(code, value);
  endtask

  // hold the sender off until every outstanding result has come back
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  function automatic logic [fcnt_pkg::REQ_W-1:0] pick_req(load_t load);
    int r;
    r = $urandom_range(0, 99);
    case (load)
      LOAD_FAILS:
        pick_req = (r < 85) ? fcnt_pkg::REQ_FAIL : (r < 90) ? fcnt_pkg::REQ_PIN_RST :
                   (r < 95) ? fcnt_pkg::REQ_READ : fcnt_pkg::REQ_NEXT;
      LOAD_COUNTER_WEAR:
        pick_req = (r < 96) ? fcnt_pkg::REQ_NEXT : (r < 97) ? fcnt_pkg::REQ_SET :
                   (r < 98) ? fcnt_pkg::REQ_FAIL : (r < 99) ? fcnt_pkg::REQ_PIN_RST :
                   fcnt_pkg::REQ_READ;
      LOAD_PIN_WEAR:
        pick_req = (r < 95) ? fcnt_pkg::REQ_PIN_RST : (r < 97) ? fcnt_pkg::REQ_FAIL :
                   (r < 98) ? fcnt_pkg::REQ_NEXT : fcnt_pkg::REQ_READ;
      default:
        pick_req = (r < 35) ? fcnt_pkg::REQ_NEXT : (r < 45) ? fcnt_pkg::REQ_SET :
                   (r < 65) ? fcnt_pkg::REQ_FAIL : (r < 75) ? fcnt_pkg::REQ_PIN_RST :
                   (r < 78) ? fcnt_pkg::REQ_CLEAR : (r < 90) ? fcnt_pkg::REQ_READ :
                   (r < 95) ? REQ_SPARE_LO : REQ_SPARE_HI;
    endcase
  endfunction

  function automatic logic [fcnt_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: pick_value = '0;
      1: pick_value = '1;
      2: pick_value = 32'hFFFF_FFFE;
      default: pick_value = $urandom;
    endcase
  endfunction

  task run_load(load_t load, int count);
    for (int i = 0; i < count; i++) begin
      // switch between idle-heavy and back-to-back stretches
      if (i % 64 == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
      send_req(pick_req(load), pick_value());
    end
    wait_drained();
  endtask

  // result side: random stalls, sampled at the edge
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    rx_stall_max = 13;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sb.checked % 50 == 0) rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(fcnt_pkg::result_t'(m_axis_tdata[RES_W-1:0]));
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    tx_gap_max = 13;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reads and spare codes, wrap of the counter, set near the top
    send_req(fcnt_pkg::REQ_READ, 32'h0);
    send_req(REQ_SPARE_LO, 32'hFFFF_FFFF);
    send_req(REQ_SPARE_HI, 32'h5A5A_A5A5);
    send_req(fcnt_pkg::REQ_NEXT, 32'hFFFF_FFFF);
    send_req(fcnt_pkg::REQ_NEXT, 32'h0);
    send_req(fcnt_pkg::REQ_FAIL, 32'h0);
    send_req(fcnt_pkg::REQ_FAIL, 32'h0);
    send_req(fcnt_pkg::REQ_PIN_RST, 32'h0);
    send_req(fcnt_pkg::REQ_SET, 32'hFFFF_FFFF);
    send_req(fcnt_pkg::REQ_NEXT, 32'h0);
    send_req(fcnt_pkg::REQ_SET, 32'hFFFF_FFFE);
    send_req(fcnt_pkg::REQ_NEXT, 32'h0);
    send_req(fcnt_pkg::REQ_NEXT, 32'h0);
    send_req(fcnt_pkg::REQ_READ, 32'hFFFF_FFFF);
    send_req(fcnt_pkg::REQ_FAIL, 32'h0);
    send_req(fcnt_pkg::REQ_PIN_RST, 32'h0);
    send_req(fcnt_pkg::REQ_CLEAR, 32'h0);
    send_req(fcnt_pkg::REQ_READ, 32'h0);
    send_req(fcnt_pkg::REQ_SET, 32'h0);
    send_req(fcnt_pkg::REQ_NEXT, 32'h0);
    send_req(fcnt_pkg::REQ_SET, 32'h8000_0001);
    send_req(fcnt_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
    wait_drained();

    // random: mixed traffic, a failure burst to reach saturation, a long run that
    // wears out the pin slots, more mixed traffic, then a stretch of counter steps
    run_load(LOAD_MIXED, 200);
    run_load(LOAD_FAILS, 80);
    run_load(LOAD_PIN_WEAR, 1150);
    run_load(LOAD_MIXED, 200);
    run_load(LOAD_COUNTER_WEAR, 150);

    repeat (8) @(posedge clk);
    $display("covered %0d results; folds from counter %0d, from pin slots %0d",
             sb.checked, sb.folds_by_counter, sb.folds_by_pin);
    $display("pin saturations %0d; spare codes seen %0d", sb.saturations,
             sb.req_seen[REQ_SPARE_LO] + sb.req_seen[REQ_SPARE_HI]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting for the result stream");
    $display("Test completed with failures");
    $finish;
  end

endmodule
